// File: sv/keyframe_spline_interpolator_top_defines.svh
// Assertion macros shared by the keyframe spline interpolator RTL.
`ifndef KEYFRAME_SPLINE_INTERPOLATOR_TOP_DEFINES_SVH
`define KEYFRAME_SPLINE_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off while reset is asserted.
`define KFI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, off while reset is asserted.
`define KFI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/kfi_pkg.sv
// Types, constants and helpers for the keyframe spline interpolator.
`default_nettype none
package kfi_pkg;

    typedef enum logic [1:0] {
        MODE_HOLD    = 2'd0,
        MODE_LINEAR  = 2'd1,
        MODE_HERMITE = 2'd2,
        MODE_BEZIER  = 2'd3
    } t_mode;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_LANES = 2'd1;
    localparam logic [1:0] CFG_HFIX  = 2'd2;

    // ratio is Q0.16 held in 17 bits (0 .. 1.0)
    localparam int Q_BITS     = 16;
    localparam int R_W        = Q_BITS + 1;
    localparam logic [R_W-1:0] ONE_Q16 = R_W'(65536);

    // divider: two quotient bits per stage, plus the setup stage
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = Q_BITS / DIV_STEPS;
    localparam int DIV_LAT    = DIV_STAGES + 1;

    // signed blend weight width
    localparam int W_W = 21;

    // round-to-nearest of a Q0.16 x Q0.16 product back to Q0.16
    function automatic logic [R_W-1:0] rnd16(input logic [2*R_W-1:0] x);
        logic [2*R_W-1:0] t;
        t = x + (2*R_W)'(32768);
        return t[Q_BITS +: R_W];
    endfunction

endpackage
`default_nettype wire

// File: sv/kfi_div.sv
// Pipelined restoring divider forming the Q0.16 key ratio, saturated to 1.0 and zero for a zero interval.
`default_nettype none
module kfi_div #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic [TIME_WIDTH-1:0]     i_time,
    input  logic [TIME_WIDTH-1:0]     i_interval,
    output logic [kfi_pkg::R_W-1:0]   o_ratio
);
    localparam int ST = kfi_pkg::DIV_STAGES;
    localparam int QB = kfi_pkg::Q_BITS;

    logic [TIME_WIDTH-1:0] r_rem  [ST+1];
    logic [TIME_WIDTH-1:0] r_ivl  [ST+1];
    logic [QB-1:0]         r_quo  [ST+1];
    logic                  r_sat  [ST+1];
    logic                  r_zero [ST+1];

    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_interval == '0);
        r_sat[0]  <= (i_time >= i_interval);
        r_rem[0]  <= i_time;
        r_ivl[0]  <= i_interval;
        r_quo[0]  <= '0;
    end

    // remainder stays below the interval once the saturated case is split off
    for (genvar k = 1; k <= ST; k++) begin : g_stage
        logic [TIME_WIDTH-1:0] n_rem;
        logic [QB-1:0]         n_quo;
        logic [TIME_WIDTH:0]   x;

        always_comb begin
            n_rem = r_rem[k-1];
            n_quo = r_quo[k-1];
            x     = '0;
            for (int j = 0; j < kfi_pkg::DIV_STEPS; j++) begin
                x = {n_rem, 1'b0};
                if (x >= {1'b0, r_ivl[k-1]}) begin
                    n_rem = TIME_WIDTH'(x - {1'b0, r_ivl[k-1]});
                    n_quo = {n_quo[QB-2:0], 1'b1};
                end else begin
                    n_rem = x[TIME_WIDTH-1:0];
                    n_quo = {n_quo[QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_quo[k]  <= n_quo;
            r_ivl[k]  <= r_ivl[k-1];
            r_sat[k]  <= r_sat[k-1];
            r_zero[k] <= r_zero[k-1];
        end
    end

    assign o_ratio = r_zero[ST] ? '0 :
                     r_sat[ST]  ? kfi_pkg::ONE_Q16 : {1'b0, r_quo[ST]};

endmodule
`default_nettype wire

// File: sv/keyframe_spline_interpolator_top.sv
// Top level of the keyframe spline interpolator: config, key pipeline, blend lanes.
`default_nettype none
// One keyframe pair enters on every cycle that start is high; busy never rises.
// Each result appears on o_blended_value with o_valid for one cycle, after
// passing in order through the ratio divider (two quotient bits a stage), the
// ratio powers, the blend weights, the lane products and the sum, rounding and
// saturation. The sink must take every result as it comes. Config writes are
// always ready and take effect at once, so they belong only in stretches with
// nothing in flight.
module keyframe_spline_interpolator_top #(
    parameter int LANES      = 4,
    parameter int LANE_WIDTH = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_time_past_key,
    input  logic [31:0] i_key_interval,
    input  logic [63:0] i_current_key,
    input  logic [63:0] i_next_key,
    input  logic [63:0] i_in_tangent,
    input  logic [63:0] i_out_tangent,
    output logic        o_valid,
    output logic [63:0] o_blended_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    localparam int R_W       = kfi_pkg::R_W;
    localparam int W_W       = kfi_pkg::W_W;
    localparam int DIV_LAT   = kfi_pkg::DIV_LAT;
    localparam int KEY_D     = DIV_LAT + 3;
    localparam int TOTAL_LAT = DIV_LAT + 5;
    localparam int KW        = LANES * LANE_WIDTH;
    localparam int LW        = LANE_WIDTH;
    localparam int DOT_W     = 2 * LW + 2;
    localparam int PROD_W    = W_W + LW + 1;
    localparam int ACC_W     = PROD_W + 2;
    localparam int SH_W      = ACC_W - kfi_pkg::Q_BITS;
    localparam logic signed [SH_W-1:0] LANE_MAX = SH_W'((1 << (LW - 1)) - 1);
    localparam logic signed [SH_W-1:0] LANE_MIN = -LANE_MAX - SH_W'(1);
    localparam logic signed [W_W-1:0]  W_ONE    = W_W'(65536);

    // ---------------- config ----------------
    kfi_pkg::t_mode r_mode;
    logic [2:0]     r_lane_count;
    logic           r_hfix;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= kfi_pkg::MODE_LINEAR;
            r_lane_count <= 3'd4;
            r_hfix       <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                kfi_pkg::CFG_MODE:  r_mode       <= kfi_pkg::t_mode'(i_cfg_data[1:0]);
                kfi_pkg::CFG_LANES: r_lane_count <= i_cfg_data[2:0];
                kfi_pkg::CFG_HFIX:  r_hfix       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic w_accept;
    assign w_accept = i_start && !o_busy;

    // ---------------- valid line ----------------
    logic [TOTAL_LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], w_accept};
        end
    end
    assign o_valid = r_vld[TOTAL_LAT-1];

    // ---------------- ratio ----------------
    logic [R_W-1:0] w_ratio;
    kfi_div #(.TIME_WIDTH(TIME_WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_time     (i_time_past_key[TIME_WIDTH-1:0]),
        .i_interval (i_key_interval[TIME_WIDTH-1:0]),
        .o_ratio    (w_ratio)
    );

    // ---------------- key delay line ----------------
    logic [KW-1:0] r_cur_d [KEY_D];
    logic [KW-1:0] r_nxt_d [KEY_D];
    logic [KW-1:0] r_itn_d [KEY_D];
    logic [KW-1:0] r_otn_d [KEY_D];

    always_ff @(posedge i_clk) begin
        r_cur_d[0] <= i_current_key[KW-1:0];
        r_nxt_d[0] <= i_next_key[KW-1:0];
        r_itn_d[0] <= i_in_tangent[KW-1:0];
        r_otn_d[0] <= i_out_tangent[KW-1:0];
        for (int k = 1; k < KEY_D; k++) begin
            r_cur_d[k] <= r_cur_d[k-1];
            r_nxt_d[k] <= r_nxt_d[k-1];
            r_itn_d[k] <= r_itn_d[k-1];
            r_otn_d[k] <= r_otn_d[k-1];
        end
    end

    // ---------------- hemisphere check ----------------
    logic signed [2*LW-1:0] r_dprod [LANES];
    logic signed [DOT_W-1:0] n_dot;
    logic                   r_flip_d [KEY_D-1];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LANES; i++) begin
            r_dprod[i] <= $signed(i_current_key[i*LW +: LW]) * $signed(i_next_key[i*LW +: LW]);
        end
    end

    always_comb begin
        n_dot = '0;
        for (int i = 0; i < LANES; i++) begin
            n_dot = n_dot + DOT_W'(r_dprod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_flip_d[0] <= r_hfix && n_dot[DOT_W-1];
        for (int k = 1; k < KEY_D - 1; k++) begin
            r_flip_d[k] <= r_flip_d[k-1];
        end
    end

    // ---------------- powers ----------------
    logic [R_W-1:0] r_p1_r, r_p1_s, r_p1_r2, r_p1_s2;
    logic [R_W-1:0] n_s;
    assign n_s = kfi_pkg::ONE_Q16 - w_ratio;

    always_ff @(posedge i_clk) begin
        r_p1_r  <= w_ratio;
        r_p1_s  <= n_s;
        r_p1_r2 <= kfi_pkg::rnd16((2*R_W)'(w_ratio) * (2*R_W)'(w_ratio));
        r_p1_s2 <= kfi_pkg::rnd16((2*R_W)'(n_s) * (2*R_W)'(n_s));
    end

    logic [R_W-1:0] r_p2_r, r_p2_s, r_p2_r2, r_p2_r3, r_p2_s3, r_p2_bo, r_p2_bi;
    always_ff @(posedge i_clk) begin
        r_p2_r  <= r_p1_r;
        r_p2_s  <= r_p1_s;
        r_p2_r2 <= r_p1_r2;
        r_p2_r3 <= kfi_pkg::rnd16((2*R_W)'(r_p1_r2) * (2*R_W)'(r_p1_r));
        r_p2_s3 <= kfi_pkg::rnd16((2*R_W)'(r_p1_s2) * (2*R_W)'(r_p1_s));
        r_p2_bo <= kfi_pkg::rnd16((2*R_W)'(r_p1_s2) * (2*R_W)'(r_p1_r));
        r_p2_bi <= kfi_pkg::rnd16((2*R_W)'(r_p1_s) * (2*R_W)'(r_p1_r2));
    end

    // ---------------- blend weights ----------------
    logic signed [W_W-1:0] w_r, w_s, w_r2, w_r3, w_s3, w_bo, w_bi;
    logic signed [W_W-1:0] n_wc, n_wo, n_wn, n_wi;
    logic signed [W_W-1:0] r_wc, r_wo, r_wn, r_wi;

    assign w_r  = $signed({{(W_W-R_W){1'b0}}, r_p2_r});
    assign w_s  = $signed({{(W_W-R_W){1'b0}}, r_p2_s});
    assign w_r2 = $signed({{(W_W-R_W){1'b0}}, r_p2_r2});
    assign w_r3 = $signed({{(W_W-R_W){1'b0}}, r_p2_r3});
    assign w_s3 = $signed({{(W_W-R_W){1'b0}}, r_p2_s3});
    assign w_bo = $signed({{(W_W-R_W){1'b0}}, r_p2_bo});
    assign w_bi = $signed({{(W_W-R_W){1'b0}}, r_p2_bi});

    always_comb begin
        n_wc = '0;
        n_wo = '0;
        n_wn = '0;
        n_wi = '0;
        case (r_mode)
            kfi_pkg::MODE_HOLD: begin
                n_wc = W_ONE;
            end
            kfi_pkg::MODE_LINEAR: begin
                n_wc = w_s;
                n_wn = w_r;
            end
            kfi_pkg::MODE_HERMITE: begin
                n_wc = W_W'(2 * w_r3 - 3 * w_r2 + W_ONE);
                n_wo = W_W'(w_r3 - 2 * w_r2 + w_r);
                n_wn = W_W'(3 * w_r2 - 2 * w_r3);
                n_wi = w_r3 - w_r2;
            end
            kfi_pkg::MODE_BEZIER: begin
                n_wc = w_s3;
                n_wo = W_W'(3 * w_bo);
                n_wi = W_W'(3 * w_bi);
                n_wn = w_r3;
            end
            default: begin
                n_wc = W_ONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_wc <= n_wc;
        r_wo <= n_wo;
        r_wn <= n_wn;
        r_wi <= n_wi;
    end

    // ---------------- lanes ----------------
    logic [2:0]   w_active;
    logic [KW-1:0] r_out;
    assign w_active = (r_lane_count > 3'(LANES)) ? 3'(LANES) : r_lane_count;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        logic signed [LW:0]       n_c, n_n, n_it, n_ot;
        logic signed [PROD_W-1:0] r_pc, r_po, r_pn, r_pi;
        logic signed [ACC_W-1:0]  n_acc;
        logic signed [SH_W-1:0]   n_sh;
        logic signed [LW-1:0]     n_v;

        assign n_c  = $signed({r_cur_d[KEY_D-1][i*LW + LW - 1], r_cur_d[KEY_D-1][i*LW +: LW]});
        assign n_it = $signed({r_itn_d[KEY_D-1][i*LW + LW - 1], r_itn_d[KEY_D-1][i*LW +: LW]});
        assign n_ot = $signed({r_otn_d[KEY_D-1][i*LW + LW - 1], r_otn_d[KEY_D-1][i*LW +: LW]});
        // flipped next key kept one bit wider so the most negative value survives
        assign n_n  = r_flip_d[KEY_D-2]
                    ? -$signed({r_nxt_d[KEY_D-1][i*LW + LW - 1], r_nxt_d[KEY_D-1][i*LW +: LW]})
                    :  $signed({r_nxt_d[KEY_D-1][i*LW + LW - 1], r_nxt_d[KEY_D-1][i*LW +: LW]});

        always_ff @(posedge i_clk) begin
            r_pc <= PROD_W'(r_wc) * PROD_W'(n_c);
            r_po <= PROD_W'(r_wo) * PROD_W'(n_ot);
            r_pn <= PROD_W'(r_wn) * PROD_W'(n_n);
            r_pi <= PROD_W'(r_wi) * PROD_W'(n_it);
        end

        always_comb begin
            n_acc = ACC_W'(r_pc) + ACC_W'(r_po) + ACC_W'(r_pn) + ACC_W'(r_pi)
                  + ACC_W'(32768);
            n_sh  = n_acc[ACC_W-1:kfi_pkg::Q_BITS];
            if (n_sh > LANE_MAX) begin
                n_v = LANE_MAX[LW-1:0];
            end else if (n_sh < LANE_MIN) begin
                n_v = LANE_MIN[LW-1:0];
            end else begin
                n_v = n_sh[LW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_out[i*LW +: LW] <= (3'(i) < w_active) ? n_v : '0;
        end
    end

    assign o_blended_value = 64'(r_out);

    // ---------------- checks ----------------
    `include "keyframe_spline_interpolator_top_defines.svh"

    `KFI_ASSERT_IMP(a_out_latency, o_valid, $past(w_accept, TOTAL_LAT), "result without matching start")
    `KFI_ASSERT_IMP(a_ratio_range, r_vld[DIV_LAT-1], w_ratio <= kfi_pkg::ONE_Q16, "ratio above 1.0")
    `KFI_ASSERT_IMP(a_no_lanes, o_valid && (r_lane_count == 3'd0), o_blended_value == 64'd0, "lanes not cleared")
    `KFI_ASSERT_IMP(a_hold_copy, o_valid && (r_mode == kfi_pkg::MODE_HOLD) && (r_lane_count >= 3'(LANES)), r_out == $past(i_current_key[KW-1:0], TOTAL_LAT), "hold differs from current key")
    `KFI_ASSERT_NXT(a_cfg_mode, i_cfg_valid && (i_cfg_index == kfi_pkg::CFG_MODE), r_mode == $past(i_cfg_data[1:0]), "mode write lost")

endmodule
`default_nettype wire

// File: tb/sv/tb_keyframe_spline_interpolator_top.sv
// Self-checking testbench for the keyframe spline interpolator top level.
`default_nettype none
module tb_keyframe_spline_interpolator_top;

    localparam int TAIL_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [31:0] i_time_past_key = '0;
    logic [31:0] i_key_interval = '0;
    logic [63:0] i_current_key = '0;
    logic [63:0] i_next_key = '0;
    logic [63:0] i_in_tangent = '0;
    logic [63:0] i_out_tangent = '0;
    logic        o_valid;
    logic [63:0] o_blended_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    keyframe_spline_interpolator_top dut (.*);

    always #1 i_clk = ~i_clk;

    typedef struct {
        logic [31:0] t_past;
        logic [31:0] t_int;
        logic [63:0] cur;
        logic [63:0] nxt;
        logic [63:0] itan;
        logic [63:0] otan;
        bit          known;
        logic [63:0] want;
    } t_key_pair;

    kfi_pkg::t_mode mode_q;
    logic [2:0] lanes_q;
    logic       hfix_q;
    logic [63:0] blend_queue[$];
    int   error_count = 0;
    longint cycle_count = 0;
    int   idle_pct = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("ERROR %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic longint lane_val(input logic [63:0] p, input int i);
        logic signed [15:0] v;
        v = p[i*16 +: 16];
        return longint'(v);
    endfunction

    function automatic longint round16(input longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic logic [63:0] predict_blend(input t_key_pair k);
        longint r, r2, r3, s, s2, s3, c, n, it, ot, acc, v, dot, sgn;
        logic [63:0] res;
        int active;
        logic [47:0] q;
        r = 0; sgn = 1; res = '0; dot = 0;
        active = (lanes_q > 4) ? 4 : int'(lanes_q);
        if (k.t_int != 0) begin
            q = {k.t_past, 16'h0} / k.t_int;
            r = (q > 65536) ? 65536 : longint'(q);
        end
        r2 = round16(r * r);
        r3 = round16(r2 * r);
        s = 65536 - r;
        s2 = round16(s * s);
        s3 = round16(s2 * s);
        if (hfix_q) begin
            for (int i = 0; i < 4; i++) dot += lane_val(k.cur, i) * lane_val(k.nxt, i);
            if (dot < 0) sgn = -1;
        end
        for (int i = 0; i < active; i++) begin
            c = lane_val(k.cur, i);
            n = lane_val(k.nxt, i) * sgn;
            it = lane_val(k.itan, i);
            ot = lane_val(k.otan, i);
            case (mode_q)
                kfi_pkg::MODE_HOLD: acc = c * 65536;
                kfi_pkg::MODE_LINEAR: acc = c * 65536 + (n - c) * r;
                kfi_pkg::MODE_HERMITE: acc = (2*r3 - 3*r2 + 65536) * c + (r3 - 2*r2 + r) * ot
                                           + (3*r2 - 2*r3) * n + (r3 - r2) * it;
                default: acc = s3 * c + 3 * round16(s2 * r) * ot
                             + 3 * round16(s * r2) * it + r3 * n;
            endcase
            v = (acc + 32768) >>> 16;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            res[i*16 +: 16] = v[15:0];
        end
        return res;
    endfunction

    // results come without back-pressure; check each against oldest expectation
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) begin
            if (blend_queue.size() == 0) begin
                report("unexpected result", o_blended_value, '0);
            end else begin
                logic [63:0] want;
                want = blend_queue.pop_front();
                if (o_blended_value !== want) report("blended_value", o_blended_value, want);
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            kfi_pkg::CFG_MODE:  mode_q = kfi_pkg::t_mode'(data[1:0]);
            kfi_pkg::CFG_LANES: lanes_q = data[2:0];
            kfi_pkg::CFG_HFIX:  hfix_q = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (blend_queue.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pair(input t_key_pair k);
        logic [63:0] want;
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_time_past_key <= k.t_past;
        i_key_interval <= k.t_int;
        i_current_key <= k.cur;
        i_next_key <= k.nxt;
        i_in_tangent <= k.itan;
        i_out_tangent <= k.otan;
        want = predict_blend(k);
        if (k.known && want !== k.want) report("table row", want, k.want);
        do @(posedge i_clk); while (o_busy);
        blend_queue.push_back(want);
    endtask

    function automatic logic [63:0] rand_lanes();
        logic [63:0] p;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(5))
                0: p[i*16 +: 16] = 16'h7fff;
                1: p[i*16 +: 16] = 16'h8000;
                2: p[i*16 +: 16] = 16'($signed($urandom_range(8192)) - 4096);
                default: p[i*16 +: 16] = $urandom;
            endcase
        end
        return p;
    endfunction

    function automatic t_key_pair rand_pair();
        t_key_pair k;
        k.t_int = ($urandom_range(9) == 0) ? 32'd0 :
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000, 1);
        case ($urandom_range(4))
            0: k.t_past = $urandom;
            1: k.t_past = k.t_int + $urandom_range(50);
            default: k.t_past = (k.t_int == 0) ? $urandom : $urandom % k.t_int;
        endcase
        k.cur = rand_lanes(); k.nxt = rand_lanes();
        k.itan = rand_lanes(); k.otan = rand_lanes();
        k.known = 0; k.want = '0;
        return k;
    endfunction

    t_key_pair directed[$];

    function automatic t_key_pair row(input logic [31:0] tp, input logic [31:0] ti,
                                      input logic [63:0] c, input logic [63:0] n,
                                      input bit kn, input logic [63:0] w);
        t_key_pair k;
        k.t_past = tp; k.t_int = ti; k.cur = c; k.nxt = n;
        k.itan = 64'h1000_f000_7fff_8000; k.otan = 64'h8000_7fff_0800_ff00;
        k.known = kn; k.want = w;
        return k;
    endfunction

    initial begin
        t_key_pair k;
        mode_q = kfi_pkg::MODE_LINEAR; lanes_q = 3'd4; hfix_q = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config is linear, four lanes: ratio 0 or 1 reads off directly
        directed = '{
            row(32'd5, 32'd0, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_0000,
                1, 64'h1111_2222_3333_4444),
            row(32'hffff_ffff, 32'd1, 64'h1111_2222_3333_4444, 64'h7fff_8000_0001_ffff,
                1, 64'h7fff_8000_0001_ffff),
            row(32'd1, 32'd2, 64'h7fff_8000_7fff_8000, 64'h8000_7fff_8000_7fff, 0, 0),
            row(32'd0, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0, 1,
                64'hffff_ffff_ffff_ffff),
            row(32'hffff_ffff, 32'hffff_ffff, 64'h0, 64'hffff_ffff_ffff_ffff, 1,
                64'hffff_ffff_ffff_ffff)
        };
        foreach (directed[i]) send_pair(directed[i]);
        i_start <= 1'b0;
        drain();

        // every mode, with flip and odd lane counts, including out-of-range ones
        for (int m = 0; m < 4; m++) begin
            for (int h = 0; h < 2; h++) begin
                write_reg(kfi_pkg::CFG_MODE, 8'(m));
                write_reg(kfi_pkg::CFG_HFIX, 8'(h));
                write_reg(kfi_pkg::CFG_LANES, (m == 0) ? 8'd0 : (m == 1) ? 8'd7 : 8'(1 + h));
                write_reg(2'd3, 8'hff);
                send_pair(row(32'd1, 32'd3, 64'h7fff_8000_4000_c000,
                              64'h8000_7fff_c000_4000, 0, 0));
                send_pair(row(32'd2, 32'd3, 64'h7fff_7fff_7fff_7fff,
                              64'h8000_8000_8000_8000, 0, 0));
                i_start <= 1'b0;
                drain();
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 10 : (ph == 1) ? 50 : 0;
            for (int set = 0; set < 6; set++) begin
                write_reg(kfi_pkg::CFG_MODE, 8'($urandom_range(3)));
                write_reg(kfi_pkg::CFG_LANES, (set == 0) ? 8'd4 : (set == 1) ? 8'd1 :
                                              8'($urandom_range(7)));
                write_reg(kfi_pkg::CFG_HFIX, 8'($urandom_range(1)));
                for (int n = 0; n < 36; n++) begin
                    k = rand_pair();
                    send_pair(k);
                end
                i_start <= 1'b0;
                drain();
            end
        end

        if (error_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
